// ----- rtl/assert_macros.svh -----
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/cse_pkg.sv -----
package cse_pkg;

   // Table size default and fixed field widths
   localparam int MAX_KNOTS_DEF = 1024;
   localparam int COUNT_W       = 11;
   localparam int INDEX_W       = 10;
   localparam int DIV_W         = 48;
   localparam int CMD_DEPTH     = 2;

   // Request kinds
   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   // Result fault codes
   localparam logic [1:0] FAULT_OK         = 2'd0;
   localparam logic [1:0] FAULT_ZERO_WIDTH = 2'd1;
   localparam logic [1:0] FAULT_SAT        = 2'd2;

   // One command beat between front and back
   typedef struct packed {
      logic                      req_type;
      logic [INDEX_W-1:0]        knot_index;
      logic signed [31:0]        knot_pos;
      logic signed [31:0]        knot_val;
      logic signed [31:0]        knot_curv;
      logic signed [31:0]        query_pos;
   } cmd_type;

   // Saturated value with its overflow flag
   typedef struct packed {
      logic               sat;
      logic signed [31:0] val;
   } sres_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_PROBE, ST_CMP, ST_RDLO, ST_RDHI, ST_GETHI, ST_HCHK,
      ST_DIVA, ST_DIVB, ST_MUL, ST_WB, ST_SUM, ST_OUT
   } state_type;

   // Multiply sequence, in issue order
   typedef enum logic [3:0] {
      OP_AA, OP_A3, OP_BB, OP_B3, OP_T1, OP_T2, OP_P1, OP_P2, OP_H2, OP_V, OP_W
   } op_type;

endpackage

// ----- rtl/cse_cmd_fifo.sv -----
module cse_cmd_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  cse_pkg::cmd_type wr_data,
   output logic             full,
   input  logic             pop,
   output cse_pkg::cmd_type rd_data,
   output logic             empty
);
   import cse_pkg::*;

   localparam int PTR_W = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;

   cmd_type            slot_ff [CMD_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]     count_ff, count_in;
   logic               do_push, do_pop;

   assign full    = (count_ff == (PTR_W+1)'(CMD_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = slot_ff[rd_ptr_ff];

   // pointer and fill tracking
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      else if (do_pop && !do_push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // payload slots
   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ptr_ff] <= wr_data;
   end

endmodule

// ----- rtl/cse_divider.sv -----
module cse_divider (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [cse_pkg::DIV_W-1:0]   dividend,
   input  logic [31:0]                 divisor,
   output logic                        done,
   output logic [cse_pkg::DIV_W-1:0]   quotient
);
   import cse_pkg::*;

   localparam int CNT_W = $clog2(DIV_W + 1);

   logic [DIV_W-1:0] quo_ff, quo_in;
   logic [31:0]      rem_ff, rem_in;
   logic [31:0]      div_ff, div_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             run_ff, run_in;
   logic             done_ff, done_in;
   logic [32:0]      trial;
   logic [32:0]      diff;
   logic             ge;

   assign done     = done_ff;
   assign quotient = quo_ff;

   // one restoring step per cycle
   assign trial = {rem_ff, quo_ff[DIV_W-1]};
   assign diff  = trial - {1'b0, div_ff};
   assign ge    = (trial >= {1'b0, div_ff});

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         div_in = divisor;
         cnt_in = CNT_W'(DIV_W);
         run_in = 1'b1;
      end else if (run_ff) begin
         rem_in = ge ? diff[31:0] : trial[31:0];
         quo_in = {quo_ff[DIV_W-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

endmodule

// ----- rtl/cse_engine.sv -----
module cse_engine #(
   parameter int MAX_KNOTS = cse_pkg::MAX_KNOTS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [cse_pkg::COUNT_W-1:0]   knot_count,
   input  logic                          cmd_empty,
   input  cse_pkg::cmd_type              cmd_data,
   output logic                          cmd_pop,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic signed [31:0]            rsp_interp_val,
   output logic [1:0]                    rsp_fault
);
   import cse_pkg::*;

   localparam int IW = $clog2(MAX_KNOTS);

   // knot tables
   logic signed [31:0] pos_mem  [MAX_KNOTS];
   logic signed [31:0] val_mem  [MAX_KNOTS];
   logic signed [31:0] curv_mem [MAX_KNOTS];
   logic signed [31:0] pos_rd_ff, val_rd_ff, curv_rd_ff;
   logic [IW-1:0]      rd_addr, wr_addr;
   logic               wr_en;

   state_type          state_ff, state_in;
   op_type             op_ff, op_in;
   logic [IW-1:0]      lo_ff, lo_in, hi_ff, hi_in, mid, lo_new, hi_new, hi_init;
   logic [31:0]        n_eff;
   logic               load_ok;
   logic signed [31:0] x_ff, x_in;
   logic signed [31:0] xlo_ff, xlo_in, ylo_ff, ylo_in, clo_ff, clo_in;
   logic signed [31:0] xhi_ff, xhi_in, yhi_ff, yhi_in, chi_ff, chi_in;
   logic signed [32:0] h_ff, h_in;
   logic [32:0]        hm;
   logic               hm_big;
   logic               neg_ff, neg_in;
   logic signed [31:0] a_ff, a_in, b_ff, b_in, tmp_ff, tmp_in;
   logic signed [31:0] ca_ff, ca_in, cb_ff, cb_in, t1_ff, t1_in, t2_ff, t2_in;
   logic signed [31:0] u_ff, u_in, h2_ff, h2_in, v_ff, v_in, w_ff, w_in;
   logic               sat_ff, sat_in;
   logic signed [31:0] res_val_ff, res_val_in;
   logic [1:0]         res_fault_ff, res_fault_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] rsp_val_ff, rsp_val_in;
   logic [1:0]         rsp_fault_ff, rsp_fault_in;
   logic signed [32:0] mul_x, mul_y;
   logic signed [65:0] prod_ff, prod_in;
   logic signed [32:0] num_d;
   logic [32:0]        num_mag;
   logic [32:0]        v_mag;
   logic [31:0]        w_mag;
   logic               div_start, div_done;
   logic [DIV_W-1:0]   div_quo;
   sres_type           q_res, r_tmp, r_div;

   // saturate a wide signed value to 32 bits
   function automatic sres_type sat32(input logic signed [49:0] v);
      sres_type r;
      r.sat = !((&v[49:31]) || (~|v[49:31]));
      r.val = r.sat ? (v[49] ? 32'sh8000_0000 : 32'sh7FFF_FFFF) : v[31:0];
      return r;
   endfunction

   cse_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({num_mag[31:0], 16'b0}),
      .divisor  (hm[31:0]),
      .done     (div_done),
      .quotient (div_quo)
   );

   // effective knot count and load range check
   always_comb begin
      if (32'(knot_count) < 32'd2) n_eff = 32'd2;
      else if (32'(knot_count) > 32'(MAX_KNOTS)) n_eff = 32'(MAX_KNOTS);
      else n_eff = 32'(knot_count);
   end
   assign hi_init = IW'(n_eff - 32'd1);
   assign load_ok = (32'(cmd_data.knot_index) < 32'(MAX_KNOTS));
   assign wr_addr = IW'(cmd_data.knot_index);
   assign mid     = IW'(({1'b0, lo_ff} + {1'b0, hi_ff}) >> 1);

   // interval width, numerators and magnitudes
   assign hm      = h_ff[32] ? 33'(-h_ff) : h_ff;
   assign hm_big  = |hm[32:24];
   assign num_d   = (state_ff == ST_HCHK) ? (33'(xhi_ff) - 33'(x_ff))
                                          : (33'(x_ff) - 33'(xlo_ff));
   assign num_mag = num_d[32] ? 33'(-num_d) : num_d;
   assign v_mag   = v_ff[31] ? 33'(-33'(v_ff)) : 33'(v_ff);
   assign w_mag   = prod_ff[65:34];
   assign q_res   = sat32(prod_ff[65:16]);
   assign r_div   = sat32(neg_ff ? -$signed({2'b0, div_quo}) : $signed({2'b0, div_quo}));

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      lo_new       = lo_ff;
      hi_new       = hi_ff;
      x_in         = x_ff;
      xlo_in       = xlo_ff;
      ylo_in       = ylo_ff;
      clo_in       = clo_ff;
      xhi_in       = xhi_ff;
      yhi_in       = yhi_ff;
      chi_in       = chi_ff;
      h_in         = h_ff;
      neg_in       = neg_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      tmp_in       = tmp_ff;
      ca_in        = ca_ff;
      cb_in        = cb_ff;
      t1_in        = t1_ff;
      t2_in        = t2_ff;
      u_in         = u_ff;
      h2_in        = h2_ff;
      v_in         = v_ff;
      w_in         = w_ff;
      sat_in       = sat_ff;
      res_val_in   = res_val_ff;
      res_fault_in = res_fault_ff;
      rsp_val_in   = rsp_val_ff;
      rsp_fault_in = rsp_fault_ff;
      rsp_valid_in = rsp_valid_ff;
      prod_in      = prod_ff;
      mul_x        = '0;
      mul_y        = '0;
      r_tmp        = '0;
      cmd_pop      = 1'b0;
      wr_en        = 1'b0;
      rd_addr      = lo_ff;
      div_start    = 1'b0;

      if (rsp_pop && rsp_valid_ff) rsp_valid_in = 1'b0;

      case (state_ff)
         // take the next command; loads finish here
         ST_IDLE: begin
            if (!cmd_empty) begin
               cmd_pop = 1'b1;
               if (cmd_data.req_type == REQ_QUERY) begin
                  x_in     = cmd_data.query_pos;
                  lo_in    = '0;
                  hi_in    = hi_init;
                  state_in = (n_eff > 32'd2) ? ST_PROBE : ST_RDLO;
               end else begin
                  wr_en = load_ok;
               end
            end
         end
         // binary search: read the midpoint, then narrow
         ST_PROBE: begin
            rd_addr  = mid;
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (pos_rd_ff > x_ff) hi_new = mid;
            else lo_new = mid;
            lo_in    = lo_new;
            hi_in    = hi_new;
            state_in = (({1'b0, hi_new} - {1'b0, lo_new}) > (IW+1)'(1)) ? ST_PROBE
                                                                         : ST_RDLO;
         end
         ST_RDLO: begin
            rd_addr  = lo_ff;
            state_in = ST_RDHI;
         end
         ST_RDHI: begin
            rd_addr  = hi_ff;
            xlo_in   = pos_rd_ff;
            ylo_in   = val_rd_ff;
            clo_in   = curv_rd_ff;
            state_in = ST_GETHI;
         end
         ST_GETHI: begin
            xhi_in   = pos_rd_ff;
            yhi_in   = val_rd_ff;
            chi_in   = curv_rd_ff;
            h_in     = 33'(pos_rd_ff) - 33'(xlo_ff);
            state_in = ST_HCHK;
         end
         // zero width check, then divide for a
         ST_HCHK: begin
            sat_in = 1'b0;
            if (h_ff == '0) begin
               res_val_in   = '0;
               res_fault_in = FAULT_ZERO_WIDTH;
               state_in     = ST_OUT;
            end else begin
               div_start = 1'b1;
               neg_in    = num_d[32] ^ h_ff[32];
               state_in  = ST_DIVA;
            end
         end
         ST_DIVA: begin
            if (div_done) begin
               a_in      = r_div.val;
               sat_in    = sat_ff | r_div.sat;
               div_start = 1'b1;
               neg_in    = num_d[32] ^ h_ff[32];
               state_in  = ST_DIVB;
            end
         end
         ST_DIVB: begin
            if (div_done) begin
               b_in     = r_div.val;
               sat_in   = sat_ff | r_div.sat;
               op_in    = OP_AA;
               state_in = ST_MUL;
            end
         end
         // shared multiplier: issue
         ST_MUL: begin
            case (op_ff)
               OP_AA:   begin mul_x = 33'(a_ff);   mul_y = 33'(a_ff);   end
               OP_A3:   begin mul_x = 33'(tmp_ff); mul_y = 33'(a_ff);   end
               OP_BB:   begin mul_x = 33'(b_ff);   mul_y = 33'(b_ff);   end
               OP_B3:   begin mul_x = 33'(tmp_ff); mul_y = 33'(b_ff);   end
               OP_T1:   begin mul_x = 33'(a_ff);   mul_y = 33'(ylo_ff); end
               OP_T2:   begin mul_x = 33'(b_ff);   mul_y = 33'(yhi_ff); end
               OP_P1:   begin mul_x = 33'(ca_ff);  mul_y = 33'(clo_ff); end
               OP_P2:   begin mul_x = 33'(cb_ff);  mul_y = 33'(chi_ff); end
               OP_H2:   begin
                  mul_x = $signed({9'b0, hm[23:0]});
                  mul_y = $signed({9'b0, hm[23:0]});
               end
               OP_V:    begin mul_x = 33'(u_ff);   mul_y = 33'(h2_ff);  end
               OP_W:    begin mul_x = $signed(v_mag); mul_y = 33'sh0_AAAA_AAAB; end
               default: begin mul_x = '0; mul_y = '0; end
            endcase
            prod_in  = mul_x * mul_y;
            state_in = ST_WB;
         end
         // shared multiplier: scale, saturate and store
         ST_WB: begin
            state_in = ST_MUL;
            op_in    = op_type'(op_ff + 4'd1);
            case (op_ff)
               OP_AA, OP_BB, OP_P1: begin
                  tmp_in = q_res.val;
                  sat_in = sat_ff | q_res.sat;
               end
               OP_A3: begin
                  r_tmp  = sat32(50'(q_res.val) - 50'(a_ff));
                  ca_in  = r_tmp.val;
                  sat_in = sat_ff | q_res.sat | r_tmp.sat;
               end
               OP_B3: begin
                  r_tmp  = sat32(50'(q_res.val) - 50'(b_ff));
                  cb_in  = r_tmp.val;
                  sat_in = sat_ff | q_res.sat | r_tmp.sat;
               end
               OP_T1: begin
                  t1_in  = q_res.val;
                  sat_in = sat_ff | q_res.sat;
               end
               OP_T2: begin
                  t2_in  = q_res.val;
                  sat_in = sat_ff | q_res.sat;
               end
               OP_P2: begin
                  r_tmp  = sat32(50'(tmp_ff) + 50'(q_res.val));
                  u_in   = r_tmp.val;
                  sat_in = sat_ff | q_res.sat | r_tmp.sat;
               end
               OP_H2: begin
                  // square of a width of 2^24 or more always overflows
                  if (hm_big || prod_ff[47]) begin
                     h2_in  = 32'sh7FFF_FFFF;
                     sat_in = 1'b1;
                  end else begin
                     h2_in = prod_ff[47:16];
                  end
               end
               OP_V: begin
                  v_in   = q_res.val;
                  sat_in = sat_ff | q_res.sat;
               end
               OP_W: begin
                  // divide by six through the reciprocal, toward zero
                  w_in     = v_ff[31] ? -$signed(w_mag) : $signed(w_mag);
                  state_in = ST_SUM;
               end
               default: state_in = ST_SUM;
            endcase
         end
         ST_SUM: begin
            r_tmp        = sat32(50'(t1_ff) + 50'(t2_ff) + 50'(w_ff));
            res_val_in   = r_tmp.val;
            res_fault_in = (sat_ff || r_tmp.sat) ? FAULT_SAT : FAULT_OK;
            state_in     = ST_OUT;
         end
         // hand over to the result register once it is free
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_pop) begin
               rsp_val_in   = res_val_ff;
               rsp_fault_in = res_fault_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      x_ff         <= x_in;
      xlo_ff       <= xlo_in;
      ylo_ff       <= ylo_in;
      clo_ff       <= clo_in;
      xhi_ff       <= xhi_in;
      yhi_ff       <= yhi_in;
      chi_ff       <= chi_in;
      h_ff         <= h_in;
      neg_ff       <= neg_in;
      a_ff         <= a_in;
      b_ff         <= b_in;
      tmp_ff       <= tmp_in;
      ca_ff        <= ca_in;
      cb_ff        <= cb_in;
      t1_ff        <= t1_in;
      t2_ff        <= t2_in;
      u_ff         <= u_in;
      h2_ff        <= h2_in;
      v_ff         <= v_in;
      w_ff         <= w_in;
      sat_ff       <= sat_in;
      res_val_ff   <= res_val_in;
      res_fault_ff <= res_fault_in;
      rsp_val_ff   <= rsp_val_in;
      rsp_fault_ff <= rsp_fault_in;
      prod_ff      <= prod_in;
   end

   // table write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         pos_mem[wr_addr]  <= cmd_data.knot_pos;
         val_mem[wr_addr]  <= cmd_data.knot_val;
         curv_mem[wr_addr] <= cmd_data.knot_curv;
      end
      pos_rd_ff  <= pos_mem[rd_addr];
      val_rd_ff  <= val_mem[rd_addr];
      curv_rd_ff <= curv_mem[rd_addr];
   end

   assign rsp_empty      = !rsp_valid_ff;
   assign rsp_interp_val = rsp_val_ff;
   assign rsp_fault      = rsp_fault_ff;

endmodule

// ----- rtl/cubic_spline_evaluator_top.sv -----
// Cubic spline evaluator, Q16.16. Load beats write one knot (position, value,
// second derivative) and return nothing; query beats return one beat with the
// interpolated value and a fault code. Beats enter a two-deep command queue and
// a single engine works them in order. A load is written as it is taken. A
// query runs a table search of ceil(log2(knot_count - 1)) probes through the
// one-read-port table, two 48-step serial divisions for a and b, eleven
// passes through one shared multiplier, and the take, table reads, width
// check, sum and hand-over. A zero-width query ends after the width check.
// The result register lets the next command start while a result waits to be
// popped; a second query that finishes before that pop waits in its last state.
// Knot tables have no reset; a query must only touch knots already loaded.
`include "assert_macros.svh"

module cubic_spline_evaluator_top #(
   parameter int MAX_KNOTS = cse_pkg::MAX_KNOTS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          req_full,
   input  logic                          req_type,
   input  logic [cse_pkg::INDEX_W-1:0]   req_knot_index,
   input  logic signed [31:0]            req_knot_pos,
   input  logic signed [31:0]            req_knot_val,
   input  logic signed [31:0]            req_knot_curv,
   input  logic signed [31:0]            req_query_pos,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic signed [31:0]            rsp_interp_val,
   output logic [1:0]                    rsp_fault,
   input  logic                          csr_wr_en,
   input  logic [cse_pkg::COUNT_W-1:0]   csr_wr_data
);
   import cse_pkg::*;

   logic [COUNT_W-1:0] count_ff, count_in;
   cmd_type            push_data, head_data;
   logic               cmd_empty, cmd_pop;

   // knot count register
   assign count_in = csr_wr_en ? csr_wr_data : count_ff;
   always_ff @(posedge clock) begin
      if (reset) count_ff <= COUNT_W'(2);
      else count_ff <= count_in;
   end

   // front: pack the beat into the command queue
   always_comb begin
      push_data.req_type   = req_type;
      push_data.knot_index = req_knot_index;
      push_data.knot_pos   = req_knot_pos;
      push_data.knot_val   = req_knot_val;
      push_data.knot_curv  = req_knot_curv;
      push_data.query_pos  = req_query_pos;
   end

   cse_cmd_fifo u_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (req_push),
      .wr_data (push_data),
      .full    (req_full),
      .pop     (cmd_pop),
      .rd_data (head_data),
      .empty   (cmd_empty)
   );

   cse_engine #(.MAX_KNOTS(MAX_KNOTS)) u_engine (
      .clock          (clock),
      .reset          (reset),
      .knot_count     (count_ff),
      .cmd_empty      (cmd_empty),
      .cmd_data       (head_data),
      .cmd_pop        (cmd_pop),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_interp_val (rsp_interp_val),
      .rsp_fault      (rsp_fault)
   );

   // checks
   `ASSERT_IMPLY(a_zero_width_val, clock, reset, !rsp_empty && rsp_fault == FAULT_ZERO_WIDTH, rsp_interp_val == '0, "zero-width result carries a value")
   `ASSERT_IMPLY(a_drain_by_pop, clock, reset, $rose(rsp_empty), $past(rsp_pop), "result lost without a pop")
   `ASSERT_NEXT(a_cfg_taken, clock, reset, csr_wr_en, count_ff == $past(csr_wr_data), "knot count write not taken")

endmodule
